/* src/bcfa_pkg.sv */
package bcfa_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    FuncMode = 2'd0,
    FuncUp   = 2'd1,
    FuncDown = 2'd2,
    FuncLoad = 2'd3
  } func_e;

  // edit mode codes
  localparam logic [3:0] ModeNone    = 4'd0;
  localparam logic [3:0] ModeSec     = 4'd1;
  localparam logic [3:0] ModeMin     = 4'd2;
  localparam logic [3:0] ModeHour    = 4'd3;
  localparam logic [3:0] ModeDate    = 4'd4;
  localparam logic [3:0] ModeMonth   = 4'd5;
  localparam logic [3:0] ModeYear    = 4'd6;
  localparam logic [3:0] ModeWeekday = 4'd7;
  localparam logic [3:0] ModeAlSec   = 4'd8;
  localparam logic [3:0] ModeAlMin   = 4'd9;
  localparam logic [3:0] ModeAlHour  = 4'd10;
  localparam logic [3:0] ModeLast    = ModeAlHour;

  function automatic logic [7:0] lim_lo(input logic [3:0] mode);
    logic [7:0] r;
    case (mode)
      ModeDate, ModeMonth, ModeWeekday: r = 8'h01;
      default:                          r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lim_hi(input logic [3:0] mode);
    logic [7:0] r;
    case (mode)
      ModeSec, ModeMin, ModeAlSec, ModeAlMin: r = 8'h59;
      ModeHour, ModeAlHour:                   r = 8'h23;
      ModeDate:                               r = 8'h31;
      ModeMonth:                              r = 8'h12;
      ModeYear:                               r = 8'h99;
      ModeWeekday:                            r = 8'h07;
      default:                                r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lim_mask(input logic [3:0] mode);
    logic [7:0] r;
    case (mode)
      ModeSec, ModeMin, ModeAlSec, ModeAlMin: r = 8'h7f;
      ModeHour, ModeAlHour, ModeDate:         r = 8'h3f;
      ModeMonth:                              r = 8'h1f;
      ModeYear:                               r = 8'hff;
      ModeWeekday:                            r = 8'h07;
      default:                                r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* src/bcfa_field_step.sv */
module bcfa_field_step (
  input  logic [7:0] val_i,
  input  logic [3:0] mode_i,
  input  logic       up_i,
  output logic [7:0] val_o
);
  import bcfa_pkg::*;

  logic [7:0] lo, hi, mask, tmp;

  always_comb begin
    lo    = lim_lo(mode_i);
    hi    = lim_hi(mode_i);
    mask  = lim_mask(mode_i);
    tmp   = 8'h00;
    val_o = 8'h00;
    if (up_i) begin
      if (val_i >= hi) begin
        val_o = lo;
      end else begin
        tmp = val_i + 8'd1;
        // skip the non-decimal low digits
        if (tmp[3:0] == 4'ha) begin
          tmp = tmp + 8'd6;
        end
        val_o = tmp & mask;
      end
    end else begin
      if (val_i <= lo) begin
        val_o = hi;
      end else begin
        tmp = val_i - 8'd1;
        if (tmp[3:0] == 4'hf) begin
          tmp = tmp - 8'd6;
        end
        val_o = tmp & mask;
      end
    end
  end

endmodule

/* src/bcd_clock_field_adjust.sv */
// BCD clock/calendar setting block. Each input transaction is a key (tuser: 0 mode, 1 up,
// 2 down) or a load of fresh clock values (tuser 3, values in tdata). Every transaction
// gives exactly one result with all clock and alarm fields, the edit mode and the alarm
// match flag, all after the update. One transaction per cycle is sustained while the result
// side is not stalled; an input register is followed by the result register, with a single BCD
// increment/decrement unit and the field registers updated in between.
module bcd_clock_field_adjust (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // load_sec, load_min, load_hour, load_weekday, load_date, load_month, load_year, zero pad
  input  logic [bcfa_pkg::InDataW-1:0]    s_axis_tdata,
  // func
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sec, minute, hour, weekday, date, month, year, alarm_sec, alarm_min, alarm_hour,
  // edit_mode, alarm_match, zero pad
  output logic [bcfa_pkg::OutDataW-1:0]   m_axis_tdata
);
  import bcfa_pkg::*;

  logic                in_valid_q;
  func_e               in_func_q;
  logic [InDataW-1:0]  in_data_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                advance;

  logic [6:0] sec_q, sec_d, min_q, min_d, al_sec_q, al_sec_d, al_min_q, al_min_d;
  logic [5:0] hour_q, hour_d, date_q, date_d, al_hour_q, al_hour_d;
  logic [2:0] wday_q, wday_d;
  logic [4:0] month_q, month_d;
  logic [7:0] year_q, year_d;
  logic [3:0] mode_q, mode_d;
  logic [7:0] sel_val, adj_val;
  logic       match;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    case (mode_q)
      ModeSec:     sel_val = {1'b0, sec_q};
      ModeMin:     sel_val = {1'b0, min_q};
      ModeHour:    sel_val = {2'b0, hour_q};
      ModeDate:    sel_val = {2'b0, date_q};
      ModeMonth:   sel_val = {3'b0, month_q};
      ModeYear:    sel_val = year_q;
      ModeWeekday: sel_val = {5'b0, wday_q};
      ModeAlSec:   sel_val = {1'b0, al_sec_q};
      ModeAlMin:   sel_val = {1'b0, al_min_q};
      ModeAlHour:  sel_val = {2'b0, al_hour_q};
      default:     sel_val = 8'h00;
    endcase
  end

  bcfa_field_step u_step (
    .val_i  (sel_val),
    .mode_i (mode_q),
    .up_i   (in_func_q == FuncUp),
    .val_o  (adj_val)
  );

  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    wday_d    = wday_q;
    date_d    = date_q;
    month_d   = month_q;
    year_d    = year_q;
    al_sec_d  = al_sec_q;
    al_min_d  = al_min_q;
    al_hour_d = al_hour_q;
    mode_d    = mode_q;
    case (in_func_q)
      FuncMode: begin
        mode_d = (mode_q < ModeLast) ? mode_q + 4'd1 : ModeNone;
      end
      FuncLoad: begin
        sec_d   = in_data_q[6:0];
        min_d   = in_data_q[13:7];
        hour_d  = in_data_q[19:14];
        wday_d  = in_data_q[22:20];
        date_d  = in_data_q[28:23];
        month_d = in_data_q[33:29];
        year_d  = in_data_q[41:34];
      end
      default: begin
        case (mode_q)
          ModeSec:     sec_d     = adj_val[6:0];
          ModeMin:     min_d     = adj_val[6:0];
          ModeHour:    hour_d    = adj_val[5:0];
          ModeDate:    date_d    = adj_val[5:0];
          ModeMonth:   month_d   = adj_val[4:0];
          ModeYear:    year_d    = adj_val;
          ModeWeekday: wday_d    = adj_val[2:0];
          ModeAlSec:   al_sec_d  = adj_val[6:0];
          ModeAlMin:   al_min_d  = adj_val[6:0];
          ModeAlHour:  al_hour_d = adj_val[5:0];
          default: ;
        endcase
      end
    endcase
    match = (hour_d == al_hour_d) && (min_d == al_min_d) && (sec_d == al_sec_d);
    out_data_d = {5'b0, match, mode_d, al_hour_d, al_min_d, al_sec_d,
                  year_d, month_d, date_d, wday_d, hour_d, min_d, sec_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sec_q       <= 7'h00;
      min_q       <= 7'h00;
      hour_q      <= 6'h00;
      wday_q      <= 3'd1;
      date_q      <= 6'h01;
      month_q     <= 5'h01;
      year_q      <= 8'h00;
      al_sec_q    <= 7'h00;
      al_min_q    <= 7'h00;
      al_hour_q   <= 6'h00;
      mode_q      <= ModeNone;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        sec_q       <= sec_d;
        min_q       <= min_d;
        hour_q      <= hour_d;
        wday_q      <= wday_d;
        date_q      <= date_d;
        month_q     <= month_d;
        year_q      <= year_d;
        al_sec_q    <= al_sec_d;
        al_min_q    <= al_min_d;
        al_hour_q   <= al_hour_d;
        mode_q      <= mode_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= func_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

/* src/bcfa_checker.sv */
module bcfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bcfa_pkg::OutDataW-1:0] m_axis_tdata
);
  import bcfa_pkg::*;

  // a stalled result transaction keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[65:62] <= ModeLast)
    else $error("edit mode out of range");

  // match flag agrees with the time and alarm fields it reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[66] == ((m_axis_tdata[6:0] == m_axis_tdata[48:42]) &&
                                           (m_axis_tdata[13:7] == m_axis_tdata[55:49]) &&
                                           (m_axis_tdata[19:14] == m_axis_tdata[61:56])))
    else $error("alarm match flag inconsistent");

endmodule

bind bcd_clock_field_adjust bcfa_checker u_bcfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/bcd_clock_field_adjust_test.sv */
module bcd_clock_field_adjust_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcfa_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // clock values carried by a load, sec in the lowest bits
  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] date;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] sec;
  } clock_load_t;

  // everything the block reports per transaction, sec in the lowest bits
  typedef struct packed {
    logic       alarm_match;
    logic [3:0] edit_mode;
    logic [5:0] alarm_hour;
    logic [6:0] alarm_min;
    logic [6:0] alarm_sec;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] date;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] sec;
  } clock_view_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  clock_view_t clock_shadow;
  clock_view_t pending_views[$];
  int          mismatches    = 0;
  int          send_idle_pct = 25;
  int          recv_idle_pct = 53;
  int          stall_len     = 0;
  int unsigned cycle_count   = 0;

  bcd_clock_field_adjust dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("bcd_clock_field_adjust_test: errors");
      $finish;
    end
  end

  // applies one key or load to the shadow clock and returns what should come out
  function automatic clock_view_t predict_step(input func_e f, input clock_load_t ld);
    logic [7:0] v;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [8:0] t;
    v  = 8'h00;
    lo = 8'h00;
    hi = 8'h00;
    case (f)
      FuncMode: begin
        clock_shadow.edit_mode = (clock_shadow.edit_mode < ModeLast) ?
                                 clock_shadow.edit_mode + 4'd1 : ModeNone;
      end
      FuncLoad: begin
        clock_shadow.sec     = ld.sec;
        clock_shadow.minute  = ld.minute;
        clock_shadow.hour    = ld.hour;
        clock_shadow.weekday = ld.weekday;
        clock_shadow.date    = ld.date;
        clock_shadow.month   = ld.month;
        clock_shadow.year    = ld.year;
      end
      default: begin
        case (clock_shadow.edit_mode)
          ModeSec:     begin v = 8'(clock_shadow.sec);        hi = 8'h59; end
          ModeMin:     begin v = 8'(clock_shadow.minute);     hi = 8'h59; end
          ModeHour:    begin v = 8'(clock_shadow.hour);       hi = 8'h23; end
          ModeDate:    begin v = 8'(clock_shadow.date);       lo = 8'h01; hi = 8'h31; end
          ModeMonth:   begin v = 8'(clock_shadow.month);      lo = 8'h01; hi = 8'h12; end
          ModeYear:    begin v = clock_shadow.year;           hi = 8'h99; end
          ModeWeekday: begin v = 8'(clock_shadow.weekday);    lo = 8'h01; hi = 8'h07; end
          ModeAlSec:   begin v = 8'(clock_shadow.alarm_sec);  hi = 8'h59; end
          ModeAlMin:   begin v = 8'(clock_shadow.alarm_min);  hi = 8'h59; end
          ModeAlHour:  begin v = 8'(clock_shadow.alarm_hour); hi = 8'h23; end
          default:     ;
        endcase
        // wrap at the limits, otherwise step with the decimal digit fix-up
        if (f == FuncUp) begin
          if (v >= hi) begin
            t = {1'b0, lo};
          end else begin
            t = v + 9'd1;
            if (t[3:0] == 4'hA) t = t + 9'd6;
          end
        end else begin
          if (v <= lo) begin
            t = {1'b0, hi};
          end else begin
            t = v - 9'd1;
            if (t[3:0] == 4'hF) t = t - 9'd6;
          end
        end
        case (clock_shadow.edit_mode)
          ModeSec:     clock_shadow.sec        = t[6:0];
          ModeMin:     clock_shadow.minute     = t[6:0];
          ModeHour:    clock_shadow.hour       = t[5:0];
          ModeDate:    clock_shadow.date       = t[5:0];
          ModeMonth:   clock_shadow.month      = t[4:0];
          ModeYear:    clock_shadow.year       = t[7:0];
          ModeWeekday: clock_shadow.weekday    = t[2:0];
          ModeAlSec:   clock_shadow.alarm_sec  = t[6:0];
          ModeAlMin:   clock_shadow.alarm_min  = t[6:0];
          ModeAlHour:  clock_shadow.alarm_hour = t[5:0];
          default:     ;
        endcase
      end
    endcase
    clock_shadow.alarm_match = (clock_shadow.hour == clock_shadow.alarm_hour) &&
                               (clock_shadow.minute == clock_shadow.alarm_min) &&
                               (clock_shadow.sec == clock_shadow.alarm_sec);
    return clock_shadow;
  endfunction

  function automatic logic [7:0] rand_bcd(input int lo_dec, input int hi_dec);
    int n;
    n = $urandom_range(hi_dec, lo_dec);
    return 8'((n / 10) * 16 + n % 10);
  endfunction

  // kind 0..5 legal time, 6..7 any bits, 8..9 legal with time equal to the alarm
  function automatic clock_load_t make_load(input int kind);
    clock_load_t ld;
    logic [63:0] raw;
    if (kind == 6 || kind == 7) begin
      raw = {$urandom, $urandom};
      ld  = raw[$bits(clock_load_t)-1:0];
    end else begin
      ld.sec     = 7'(rand_bcd(0, 59));
      ld.minute  = 7'(rand_bcd(0, 59));
      ld.hour    = 6'(rand_bcd(0, 23));
      ld.weekday = 3'($urandom_range(7, 1));
      ld.date    = 6'(rand_bcd(1, 31));
      ld.month   = 5'(rand_bcd(1, 12));
      ld.year    = rand_bcd(0, 99);
      if (kind >= 8) begin
        ld.sec    = clock_shadow.alarm_sec;
        ld.minute = clock_shadow.alarm_min;
        ld.hour   = clock_shadow.alarm_hour;
      end
    end
    return ld;
  endfunction

  task automatic send_item(input func_e f, input clock_load_t ld);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= InDataW'(ld);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_views.push_back(predict_step(f, ld));
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_views.size() != 0);
  endtask

  task automatic test_ignored_keys();
    send_item(FuncUp, make_load(6));
    send_item(FuncDown, make_load(6));
  endtask

  task automatic test_load_extremes();
    send_item(FuncLoad, '1);
    send_item(FuncLoad, '0);
  endtask

  // every field starts at zero, so each down key wraps to the field's top
  task automatic test_down_wrap_each_mode();
    for (int m = 1; m <= 10; m++) begin
      send_item(FuncMode, make_load(6));
      send_item(FuncDown, make_load(6));
    end
    send_item(FuncMode, make_load(6));
  endtask

  task automatic test_random_editing(input int n, input int send_pct, input int recv_pct);
    int   done;
    int   burst;
    bit   go_up;
    func_e f;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          send_item(FuncMode, make_load(6));
          done++;
        end
        3: begin
          send_item(FuncLoad, make_load($urandom_range(9)));
          done++;
        end
        default: begin
          // runs of keys mostly in one direction reach the wrap points
          go_up = 1'($urandom_range(1));
          burst = ($urandom_range(9) == 0) ? $urandom_range(70, 30) : $urandom_range(20, 1);
          repeat (burst) begin
            f = (go_up ^ ($urandom_range(9) == 0)) ? FuncUp : FuncDown;
            if (clock_shadow.edit_mode != ModeNone) done++;
            send_item(f, make_load(6));
          end
        end
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len = 300;
    repeat (40) send_item($urandom_range(1) ? FuncUp : FuncMode, make_load(6));
  endtask

  task automatic test_drain_pause();
    repeat (10) send_item(FuncDown, make_load(6));
    wait_all_results();
    repeat (10) send_item(FuncLoad, make_load($urandom_range(9)));
  endtask

  // result side: random ready, with a long hold when one is requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_len > 0) begin
        hold_left = stall_len;
        stall_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    clock_view_t want;
    clock_view_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = clock_view_t'(m_axis_tdata[$bits(clock_view_t)-1:0]);
      if (pending_views.size() == 0) begin
        $error("result transaction with none outstanding: 0x%0h", got);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("sec", 32'(want.sec), 32'(got.sec));
        check_field("minute", 32'(want.minute), 32'(got.minute));
        check_field("hour", 32'(want.hour), 32'(got.hour));
        check_field("weekday", 32'(want.weekday), 32'(got.weekday));
        check_field("date", 32'(want.date), 32'(got.date));
        check_field("month", 32'(want.month), 32'(got.month));
        check_field("year", 32'(want.year), 32'(got.year));
        check_field("alarm_sec", 32'(want.alarm_sec), 32'(got.alarm_sec));
        check_field("alarm_min", 32'(want.alarm_min), 32'(got.alarm_min));
        check_field("alarm_hour", 32'(want.alarm_hour), 32'(got.alarm_hour));
        check_field("edit_mode", 32'(want.edit_mode), 32'(got.edit_mode));
        check_field("alarm_match", 32'(want.alarm_match), 32'(got.alarm_match));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FuncMode;
    clock_shadow  = '0;
    clock_shadow.weekday = 3'd1;
    clock_shadow.date    = 6'h01;
    clock_shadow.month   = 5'h01;
    clock_shadow.edit_mode = ModeNone;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_keys();
    test_load_extremes();
    test_down_wrap_each_mode();
    test_random_editing(310, 25, 53);
    test_random_editing(310, 53, 25);
    test_random_editing(310, 0, 0);
    test_output_backpressure();
    test_drain_pause();

    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bcd_clock_field_adjust_test: clean");
    end else begin
      $display("bcd_clock_field_adjust_test: errors");
    end
    $finish;
  end

endmodule
